// File: rtl/ihds_pkg.sv
package ihds_pkg;

    // Sizes
    localparam int HEADER_LEN  = 24;
    localparam int HDR_IDX_W   = $clog2(HEADER_LEN);
    localparam int POS_BITS    = 32;
    localparam int OFFSET_BITS = 32;
    localparam int SUM_W       = OFFSET_BITS + 2;
    localparam int DIM_W       = 33;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_TRUNC   = 2'd2;
    localparam logic [1:0] ST_UNSUPP  = 2'd3;

    // Image kinds
    localparam logic [1:0] KIND_JPEG = 2'd0;
    localparam logic [1:0] KIND_GIF  = 2'd1;
    localparam logic [1:0] KIND_PNG  = 2'd2;
    localparam logic [1:0] KIND_SWF  = 2'd3;

    // Early guess from the first three bytes
    localparam logic [2:0] DK_NONE  = 3'd0;
    localparam logic [2:0] DK_FWS   = 3'd1;
    localparam logic [2:0] DK_CWS   = 3'd2;
    localparam logic [2:0] DK_FF    = 3'd3;
    localparam logic [2:0] DK_OTHER = 3'd4;

    // JPEG segment walk states
    localparam logic [1:0] WALK_SCAN = 2'd0;
    localparam logic [1:0] WALK_FAIL = 2'd1;
    localparam logic [1:0] WALK_SOF  = 2'd2;
    localparam logic [1:0] WALK_DONE = 2'd3;

    // JPEG markers
    localparam logic [7:0] MRK_PREFIX = 8'hFF;
    localparam logic [7:0] MRK_SOI    = 8'hD8;
    localparam logic [7:0] MRK_APP0   = 8'hE0;
    localparam logic [7:0] MRK_EOI    = 8'hD9;
    localparam logic [7:0] MRK_SOF0   = 8'hC0;
    localparam logic [7:0] MRK_SOF1   = 8'hC1;
    localparam logic [7:0] MRK_SOF2   = 8'hC2;
    localparam logic [7:0] MRK_SOF9   = 8'hC9;
    localparam logic [7:0] MRK_SOF10  = 8'hCA;
    localparam logic [7:0] MRK_SOF11  = 8'hCB;
    localparam logic [7:0] MRK_RST0   = 8'hD0;
    localparam logic [7:0] PNG_SIG0   = 8'h89;

    typedef logic [HEADER_LEN-1:0][7:0] hdr_t;

    // Per-word control shared by the parsers
    typedef struct packed {
        logic                step;
        logic                restart;
        logic                saturated;
        logic [POS_BITS-1:0] position;
        logic [7:0]          data_byte;
    } ihds_step_t;

    typedef struct packed {
        logic [1:0]  walk_state;
        logic [15:0] width;
        logic [15:0] height;
    } ihds_jpeg_t;

    typedef struct packed {
        logic                    done;
        logic signed [DIM_W-1:0] width;
        logic signed [DIM_W-1:0] height;
    } ihds_rect_t;

    typedef struct packed {
        logic signed [DIM_W-1:0] height;
        logic signed [DIM_W-1:0] width;
        logic [1:0]              kind;
        logic [1:0]              status;
    } ihds_result_t;

    localparam int RES_W      = $bits(ihds_result_t);
    localparam int M_TDATA_W  = ((RES_W + 7) / 8) * 8;

    function automatic logic is_sof(input logic [7:0] m);
        return m == MRK_SOF0 || m == MRK_SOF1 || m == MRK_SOF2 ||
               m == MRK_SOF9 || m == MRK_SOF10 || m == MRK_SOF11;
    endfunction

    // Stand-alone markers RST0..RST7 and SOI
    function automatic logic is_bare(input logic [7:0] m);
        return m >= MRK_RST0 && m <= MRK_SOI;
    endfunction

endpackage

// File: rtl/ihds_jpeg_walk.sv
module ihds_jpeg_walk (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ihds_pkg::ihds_step_t ctl,
    input  logic                 jpeg_kind,
    output ihds_pkg::ihds_jpeg_t walk
);
    import ihds_pkg::*;

    logic [1:0]             state_reg, state_next;
    logic [OFFSET_BITS-1:0] seg_start_reg, seg_start_next;
    logic [7:0]             prev_reg, prev_next;
    logic [15:0]            wid_reg, wid_next;
    logic [15:0]            hgt_reg, hgt_next;

    logic [POS_BITS:0]      diff;
    logic                   reached;
    logic [POS_BITS-1:0]    rel;
    logic [15:0]            seg_len;
    logic [16:0]            adv;
    logic [SUM_W-1:0]       sum;
    logic                   ovf;

    // Distance of this word from the current segment start
    assign diff    = (POS_BITS + 1)'(ctl.position) - (POS_BITS + 1)'(seg_start_reg);
    assign reached = !diff[POS_BITS];
    assign rel     = diff[POS_BITS-1:0];

    // Next segment start: length field plus marker, or two for a bare marker
    assign seg_len = {prev_reg, ctl.data_byte};
    assign adv     = (reached && rel == POS_BITS'(3)) ? 17'(seg_len) + 17'd2 : 17'd2;
    assign sum     = SUM_W'(seg_start_reg) + SUM_W'(adv);
    assign ovf     = |sum[SUM_W-1:OFFSET_BITS];

    always_comb begin
        state_next     = state_reg;
        seg_start_next = seg_start_reg;
        prev_next      = prev_reg;
        wid_next       = wid_reg;
        hgt_next       = hgt_reg;
        if (ctl.step) begin
            prev_next = ctl.data_byte;
            if (ctl.saturated) begin
                if (state_reg == WALK_SCAN || state_reg == WALK_SOF) begin
                    state_next = WALK_FAIL;
                end
            end else if (reached) begin
                unique case (state_reg)
                    WALK_SCAN: begin
                        if (rel == POS_BITS'(1)) begin
                            if (prev_reg != MRK_PREFIX || ctl.data_byte == MRK_EOI) begin
                                state_next = WALK_FAIL;
                            end else if (is_sof(ctl.data_byte)) begin
                                state_next = WALK_SOF;
                            end else if (is_bare(ctl.data_byte)) begin
                                if (ovf) state_next = WALK_FAIL;
                                else     seg_start_next = sum[OFFSET_BITS-1:0];
                            end
                        end else if (rel == POS_BITS'(3)) begin
                            // a zero length lands on the length bytes, never a marker
                            if (ovf) begin
                                state_next = WALK_FAIL;
                            end else begin
                                seg_start_next = sum[OFFSET_BITS-1:0];
                                if (seg_len == 16'd0) state_next = WALK_FAIL;
                            end
                        end
                    end
                    WALK_SOF: begin
                        if (jpeg_kind) begin
                            if (rel == POS_BITS'(5)) hgt_next[15:8] = ctl.data_byte;
                            if (rel == POS_BITS'(6)) hgt_next[7:0]  = ctl.data_byte;
                            if (rel == POS_BITS'(7)) wid_next[15:8] = ctl.data_byte;
                            if (rel == POS_BITS'(8)) wid_next[7:0]  = ctl.data_byte;
                        end
                        if (rel == POS_BITS'(11)) state_next = WALK_DONE;
                    end
                    WALK_FAIL, WALK_DONE: begin
                    end
                endcase
            end
        end
    end

    // Hold walk state; return to the first segment after each file
    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.restart) begin
            state_reg     <= WALK_SCAN;
            seg_start_reg <= OFFSET_BITS'(2);
        end else begin
            state_reg     <= state_next;
            seg_start_reg <= seg_start_next;
        end
    end

    always_ff @(posedge aclk) begin
        prev_reg <= prev_next;
        wid_reg  <= wid_next;
        hgt_reg  <= hgt_next;
    end

    assign walk.walk_state = state_next;
    assign walk.width      = wid_next;
    assign walk.height     = hgt_next;

endmodule

// File: rtl/ihds_swf_rect.sv
module ihds_swf_rect (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ihds_pkg::ihds_step_t ctl,
    input  logic                 take,
    output ihds_pkg::ihds_rect_t rect
);
    import ihds_pkg::*;

    localparam logic [2:0] NB_LEN    = 3'd5;
    localparam logic [2:0] FLD_XMIN  = 3'd0;
    localparam logic [2:0] FLD_XMAX  = 3'd1;
    localparam logic [2:0] FLD_YMAX  = 3'd3;
    localparam logic [2:0] FLD_DONE  = 3'd4;

    logic [2:0]              hc_reg,  hc_next;
    logic [4:0]              nb_reg,  nb_next;
    logic [2:0]              fld_reg, fld_next;
    logic [4:0]              cnt_reg, cnt_next;
    logic signed [DIM_W-1:0] wid_reg, wid_next;
    logic signed [DIM_W-1:0] hgt_reg, hgt_next;

    // Walk the eight bits of the word, MSB first, through the RECT fields
    always_comb begin
        logic [5:0] idx;
        idx      = '0;
        hc_next  = hc_reg;
        nb_next  = nb_reg;
        fld_next = fld_reg;
        cnt_next = cnt_reg;
        wid_next = wid_reg;
        hgt_next = hgt_reg;
        for (int k = 7; k >= 0; k--) begin
            if (take) begin
                if (hc_next < NB_LEN) begin
                    nb_next = {nb_next[3:0], ctl.data_byte[k]};
                    hc_next = hc_next + 3'd1;
                    if (hc_next == NB_LEN) begin
                        fld_next = (nb_next == 5'd0) ? FLD_DONE : FLD_XMIN;
                        cnt_next = 5'd0;
                    end
                end else if (fld_next != FLD_DONE) begin
                    idx = 6'(nb_next) - 6'd1 - 6'(cnt_next);
                    // first bit is the sign: fill, then set the lower bits
                    if (fld_next == FLD_XMAX) begin
                        if (cnt_next == 5'd0) wid_next = {DIM_W{ctl.data_byte[k]}};
                        else                  wid_next[idx] = ctl.data_byte[k];
                    end
                    if (fld_next == FLD_YMAX) begin
                        if (cnt_next == 5'd0) hgt_next = {DIM_W{ctl.data_byte[k]}};
                        else                  hgt_next[idx] = ctl.data_byte[k];
                    end
                    if (cnt_next == nb_next - 5'd1) begin
                        cnt_next = 5'd0;
                        fld_next = fld_next + 3'd1;
                    end else begin
                        cnt_next = cnt_next + 5'd1;
                    end
                end
            end
        end
    end

    // Hold parse state; clear after each file
    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.restart) begin
            hc_reg  <= '0;
            nb_reg  <= '0;
            fld_reg <= FLD_XMIN;
            cnt_reg <= '0;
            wid_reg <= '0;
            hgt_reg <= '0;
        end else begin
            hc_reg  <= hc_next;
            nb_reg  <= nb_next;
            fld_reg <= fld_next;
            cnt_reg <= cnt_next;
            wid_reg <= wid_next;
            hgt_reg <= hgt_next;
        end
    end

    assign rect.done   = (hc_next == NB_LEN) && (fld_next == FLD_DONE);
    assign rect.width  = wid_next;
    assign rect.height = hgt_next;

endmodule

// File: rtl/ihds_classify.sv
module ihds_classify (
    input  ihds_pkg::hdr_t         hdr,
    input  logic                   short_file,
    input  logic [2:0]             guess,
    input  ihds_pkg::ihds_jpeg_t   walk,
    input  ihds_pkg::ihds_rect_t   rect,
    output ihds_pkg::ihds_result_t res
);
    import ihds_pkg::*;

    logic is_jfif, is_gif, is_png;

    // Match the fixed signatures
    assign is_jfif = hdr[0] == MRK_PREFIX && hdr[1] == MRK_SOI &&
                     hdr[2] == MRK_PREFIX && hdr[3] == MRK_APP0 &&
                     {hdr[6], hdr[7], hdr[8], hdr[9]} == "JFIF";
    assign is_gif  = {hdr[0], hdr[1], hdr[2]} == "GIF";
    assign is_png  = hdr[0] == PNG_SIG0 && {hdr[1], hdr[2], hdr[3]} == "PNG" &&
                     {hdr[4], hdr[5], hdr[6], hdr[7]} == 32'h0D0A1A0A &&
                     {hdr[12], hdr[13], hdr[14], hdr[15]} == "IHDR";

    // Pick the result; earlier tests take precedence
    always_comb begin
        res        = '0;
        res.status = ST_UNKNOWN;
        res.kind   = KIND_JPEG;
        priority if (short_file) begin
            res.status = ST_TRUNC;
        end else if (is_jfif) begin
            if (walk.walk_state == WALK_DONE) begin
                res.status = ST_OK;
                res.width  = DIM_W'(walk.width);
                res.height = DIM_W'(walk.height);
            end else begin
                res.status = ST_TRUNC;
            end
        end else if (is_gif) begin
            res.status = ST_OK;
            res.kind   = KIND_GIF;
            res.width  = DIM_W'({hdr[7], hdr[6]});
            res.height = DIM_W'({hdr[9], hdr[8]});
        end else if (is_png) begin
            res.status = ST_OK;
            res.kind   = KIND_PNG;
            res.width  = DIM_W'({hdr[16], hdr[17], hdr[18], hdr[19]});
            res.height = DIM_W'({hdr[20], hdr[21], hdr[22], hdr[23]});
        end else if (guess == DK_FWS) begin
            if (rect.done) begin
                res.status = ST_OK;
                res.kind   = KIND_SWF;
                res.width  = rect.width;
                res.height = rect.height;
            end else begin
                res.status = ST_TRUNC;
            end
        end else if (guess == DK_CWS) begin
            res.status = ST_UNSUPP;
            res.kind   = KIND_SWF;
        end else begin
            res.status = ST_UNKNOWN;
        end
    end

endmodule

// File: rtl/image_header_dimension_sniffer.sv
// Result path: the last word is held in the input register, then loaded into the result register that drives m_tvalid.
// Throughput: one word per cycle; a last word waits only while the previous result
// sits untaken in the output register.
// Per-word work is one pass of compare, offset add and bit-field logic between the
// input register and the result register.
// Reset: synchronous, aresetn low; the parser also returns to reset after each result.
module image_header_dimension_sniffer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] data_byte
    input  logic                           s_tlast,   // last
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ihds_pkg::M_TDATA_W-1:0] m_tdata    // [1:0] status, [3:2] image_kind,
                                                      // [36:4] width, [69:37] height
);
    import ihds_pkg::*;

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_last_reg;
    logic [POS_BITS-1:0]  pos_reg, pos_next;
    logic [2:0]           dk_reg, dk_next, dk_now;
    hdr_t                 hdr_reg, hdr_view;
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    logic                 proceed;
    logic                 restart;
    logic                 saturated;
    logic                 short_file;
    logic                 rect_take;
    ihds_step_t           ctl;
    ihds_jpeg_t           walk;
    ihds_rect_t           rect;
    ihds_result_t         res;
    ihds_result_t         m_res;

    // Advance the input register unless a last word meets a full result register that m_tready does not drain
    assign proceed  = in_valid_reg && (!in_last_reg || !m_valid_reg || m_tready);
    assign restart  = proceed && in_last_reg;
    assign s_tready = !in_valid_reg || proceed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Byte count, held at full scale
    assign saturated = &pos_reg;
    assign pos_next  = restart ? '0 :
                       (proceed && !saturated) ? pos_reg + POS_BITS'(1) : pos_reg;

    // Format guess from the first three bytes
    always_comb begin
        dk_now = dk_reg;
        if (pos_reg == POS_BITS'(2)) begin
            if ({hdr_reg[1], in_byte_reg} == "WS" && hdr_reg[0] == "F") begin
                dk_now = DK_FWS;
            end else if ({hdr_reg[1], in_byte_reg} == "WS" &&
                         (hdr_reg[0] == "C" || hdr_reg[0] == "Z")) begin
                dk_now = DK_CWS;
            end else if (hdr_reg[0] == MRK_PREFIX) begin
                dk_now = DK_FF;
            end else begin
                dk_now = DK_OTHER;
            end
        end
    end
    assign dk_next = restart ? DK_NONE : (proceed ? dk_now : dk_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            dk_reg  <= DK_NONE;
        end else begin
            pos_reg <= pos_next;
            dk_reg  <= dk_next;
        end
    end

    // Header store, seen with the current word already in place
    always_comb begin
        for (int i = 0; i < HEADER_LEN; i++) begin
            hdr_view[i] = (pos_reg == POS_BITS'(i)) ? in_byte_reg : hdr_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (proceed && pos_reg < POS_BITS'(HEADER_LEN)) begin
            hdr_reg[pos_reg[HDR_IDX_W-1:0]] <= in_byte_reg;
        end
    end

    assign short_file = pos_reg < POS_BITS'(HEADER_LEN - 1);

    assign ctl.step      = proceed;
    assign ctl.restart   = restart;
    assign ctl.saturated = saturated;
    assign ctl.position  = pos_reg;
    assign ctl.data_byte = in_byte_reg;

    ihds_jpeg_walk u_jpeg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .jpeg_kind (dk_reg == DK_FF),
        .walk      (walk)
    );

    assign rect_take = proceed && dk_now == DK_FWS && pos_reg >= POS_BITS'(8);

    ihds_swf_rect u_rect (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .take    (rect_take),
        .rect    (rect)
    );

    ihds_classify u_classify (
        .hdr        (hdr_view),
        .short_file (short_file),
        .guess      (dk_now),
        .walk       (walk),
        .rect       (rect),
        .res        (res)
    );

    // Result register: load at the last word, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (restart) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (restart) begin
            m_data_reg <= {{(M_TDATA_W - RES_W){1'b0}}, res};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_res    = ihds_result_t'(m_data_reg[RES_W-1:0]);

    a_fail_zero_dims: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_res.status != ST_OK |-> m_res.width == '0 && m_res.height == '0)
        else $error("dimensions not zero on a failed result");

    a_unsupp_is_swf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_res.status == ST_UNSUPP |-> m_res.kind == KIND_SWF)
        else $error("unsupported result without SWF kind");

    a_mid_word_flows: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !in_last_reg |-> proceed)
        else $error("non-last word stalled");

    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        restart |=> pos_reg == '0 && dk_reg == DK_NONE && m_valid_reg)
        else $error("state not cleared after result");

endmodule
